@@ design/brb_pkg.sv @@
// brb_pkg: shared constants, command and status codes, and the
// controller/datapath interface structs of the byte ring buffer.
// No dependencies.
package brb_pkg;

  // field widths
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 9;
  localparam int STAT_W = 2;
  localparam int CMD_W  = 3;

  // default store depth and longest read or peek run
  localparam int DEPTH_DEF = 256;
  localparam int MAX_CHUNK = 64;
  localparam int CHUNK_W   = $clog2(MAX_CHUNK + 1);

  // command codes
  localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DISCARD = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SHORT = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic accept;  // input transaction taken this cycle
    logic issue;   // read the next run byte from the store
    logic load;    // move the fetched run byte into the output register
  } brb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic run_start;  // offered item is a good read or peek of one or more bytes
    logic more;       // run bytes still to fetch
    logic pend;       // fetched run byte waiting for the output register
    logic last_load;  // the waiting byte is the final one of the run
  } brb_stat_t;

endpackage

@@ design/byte_ring_buffer_block_ops.sv @@
// byte_ring_buffer_block_ops: top level of the byte ring buffer; joins the
// controller and the datapath.
// Depends on brb_pkg, brb_ctrl and brb_dp.
//
//   channel  | handshake           | fields
//   ---------+---------------------+-----------------------------------------------
//   in_      | in_valid / in_stall | command, data_byte, length, block_start
//   out_     | out_valid/out_stall | read_byte, status, count, fill_level,
//            |                     | free_space, last
//
// A write, discard, clear, rejected read or unknown command gives its result the
// cycle after it is taken; items follow each other every cycle while out_stall
// stays low. A good read or peek of n bytes takes the item, then fetches each
// byte from the registered store read and moves it into the result register,
// one byte per cycle while out_stall stays low.
// Reset is synchronous on rst_n and clears indices, flags and the controller;
// the byte store itself is not cleared. out_stall holds the current result,
// and in_stall stays high until that result has been taken.
module byte_ring_buffer_block_ops
  import brb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [BYTE_W-1:0]  in_data_byte,
  input  logic [LEN_W-1:0]   in_length,
  input  logic               in_block_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [BYTE_W-1:0]  out_read_byte,
  output logic [STAT_W-1:0]  out_status,
  output logic [LEN_W-1:0]   out_count,
  output logic [LEN_W-1:0]   out_fill_level,
  output logic [LEN_W-1:0]   out_free_space,
  output logic               out_last
);

  brb_cmd_t  cmd;
  brb_stat_t stat;

  // handshakes and run sequencing
  brb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // store, pointers and results
  brb_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_command     (in_command),
    .in_data_byte   (in_data_byte),
    .in_length      (in_length),
    .in_block_start (in_block_start),
    .cmd            (cmd),
    .stat           (stat),
    .out_read_byte  (out_read_byte),
    .out_status     (out_status),
    .out_count      (out_count),
    .out_fill_level (out_fill_level),
    .out_free_space (out_free_space),
    .out_last       (out_last)
  );

endmodule

@@ design/brb_ctrl.sv @@
// brb_ctrl: controller state machine of the byte ring buffer; owns the
// channel handshakes and sequences read and peek runs.
// Depends on brb_pkg.
module brb_ctrl
  import brb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  brb_stat_t stat,
  output brb_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // output register can take a new result this cycle
  assign out_free = !out_valid_r || !out_stall;

  // input is taken only when idle and the output side has room
  assign in_stall = !((state_r == ST_IDLE) && out_free);
  assign out_valid = out_valid_r;

  // datapath commands
  always_comb begin
    cmd.accept = in_valid && !in_stall;
    cmd.load   = (state_r == ST_RUN) && stat.pend && out_free;
    cmd.issue  = (state_r == ST_RUN) && stat.more && (!stat.pend || cmd.load);
  end

  // next state and output valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (cmd.accept) begin
          if (stat.run_start) begin
            state_nxt = ST_RUN;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_RUN: begin
        if (cmd.load) begin
          out_valid_nxt = 1'b1;
          if (stat.last_load) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  // a run begins with an empty output register
  a_run_enter: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && stat.run_start |=> (state_r == ST_RUN) && !out_valid_r)
    else $error("run did not start cleanly");

  // the final run byte returns the controller to idle
  a_run_exit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load && stat.last_load |=> (state_r == ST_IDLE) && out_valid_r)
    else $error("run did not end after its last byte");
`endif

endmodule

@@ design/brb_dp.sv @@
// brb_dp: datapath of the byte ring buffer: byte store, indices, full
// flag, pending write block, run counters and result registers.
// Depends on brb_pkg.
module brb_dp
  import brb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [BYTE_W-1:0]  in_data_byte,
  input  logic [LEN_W-1:0]   in_length,
  input  logic               in_block_start,
  input  brb_cmd_t           cmd,
  output brb_stat_t          stat,
  output logic [BYTE_W-1:0]  out_read_byte,
  output logic [STAT_W-1:0]  out_status,
  output logic [LEN_W-1:0]   out_count,
  output logic [LEN_W-1:0]   out_fill_level,
  output logic [LEN_W-1:0]   out_free_space,
  output logic               out_last
);

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int SUM_W  = IDX_W + 1;
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int CMP_W  = (FILL_W > LEN_W) ? FILL_W : LEN_W;

  // index step with wrap; step never exceeds DEPTH
  function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] i,
                                               input logic [SUM_W-1:0] step);
    logic [SUM_W-1:0] s;
    s = SUM_W'(i) + step;
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  logic [BYTE_W-1:0]  mem [DEPTH];
  logic [BYTE_W-1:0]  mem_q_r;

  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]   wr_idx_r, wr_idx_nxt;
  logic               full_r, full_nxt;
  logic [LEN_W-1:0]   blk_left_r, blk_left_nxt;
  logic               blk_rej_r, blk_rej_nxt;

  logic [IDX_W-1:0]   run_ptr_r;
  logic [CHUNK_W-1:0] run_len_r;
  logic [CHUNK_W-1:0] issue_left_r;
  logic [CHUNK_W-1:0] load_left_r;
  logic               pend_r;

  logic [BYTE_W-1:0]  res_byte_r;
  logic [STAT_W-1:0]  res_status_r, res_status_nxt;
  logic [LEN_W-1:0]   res_count_r, res_count_nxt;
  logic               res_last_r, res_last_nxt;

  logic [FILL_W-1:0]  fill, free;
  logic [CMP_W-1:0]   len_c, fill_c, free_c;
  logic               len_over_depth, len_over_chunk;
  logic               run_ok;
  logic               mem_we;
  logic [IDX_W-1:0]   wr_step;
  logic               wr_skip;
  logic               wr_rej;
  logic [LEN_W-1:0]   wr_left;

  // fill level and free space from the indices and full flag
  always_comb begin
    if (full_r) begin
      fill = FILL_W'(DEPTH);
    end else if (wr_idx_r >= rd_idx_r) begin
      fill = FILL_W'(wr_idx_r) - FILL_W'(rd_idx_r);
    end else begin
      fill = FILL_W'(DEPTH) - FILL_W'(rd_idx_r) + FILL_W'(wr_idx_r);
    end
    free = FILL_W'(DEPTH) - fill;
  end

  // length checks
  assign len_c          = CMP_W'(in_length);
  assign fill_c         = CMP_W'(fill);
  assign free_c         = CMP_W'(free);
  assign len_over_depth = len_c > CMP_W'(DEPTH);
  assign len_over_chunk = (in_length > LEN_W'(MAX_CHUNK)) || len_over_depth;
  assign run_ok         = ((in_command == CMD_READ) || (in_command == CMD_PEEK)) &&
                          (in_length != '0) && !len_over_chunk && !(len_c > fill_c);
  assign wr_step        = idx_add(wr_idx_r, SUM_W'(1));

  // step of the offered item
  always_comb begin
    rd_idx_nxt     = rd_idx_r;
    wr_idx_nxt     = wr_idx_r;
    full_nxt       = full_r;
    blk_left_nxt   = blk_left_r;
    blk_rej_nxt    = blk_rej_r;
    res_status_nxt = STAT_OK;
    res_count_nxt  = '0;
    res_last_nxt   = 1'b1;
    mem_we         = 1'b0;
    wr_skip        = 1'b0;
    wr_rej         = blk_rej_r;
    wr_left        = blk_left_r;
    case (in_command)
      CMD_WRITE: begin
        if (in_block_start) begin
          if (in_length == '0) begin
            wr_skip      = 1'b1;
            blk_left_nxt = '0;
            blk_rej_nxt  = 1'b0;
          end else begin
            if (len_over_depth) begin
              res_status_nxt = STAT_RANGE;
            end else if (len_c > free_c) begin
              res_status_nxt = STAT_SHORT;
            end
            wr_rej  = len_over_depth || (len_c > free_c);
            wr_left = in_length;
          end
        end else if (blk_left_r == '0) begin
          // stray byte with no block to belong to
          wr_skip        = 1'b1;
          res_status_nxt = STAT_SHORT;
        end else if (blk_rej_r) begin
          res_status_nxt = STAT_SHORT;
        end
        if (!wr_skip) begin
          if (!wr_rej) begin
            mem_we        = 1'b1;
            wr_idx_nxt    = wr_step;
            full_nxt      = full_r || (wr_step == rd_idx_r);
            res_count_nxt = LEN_W'(1);
          end
          wr_left      = wr_left - LEN_W'(1);
          blk_left_nxt = wr_left;
          blk_rej_nxt  = (wr_left == '0) ? 1'b0 : wr_rej;
          res_last_nxt = (wr_left == '0);
        end
      end
      CMD_READ, CMD_PEEK: begin
        blk_left_nxt = '0;
        blk_rej_nxt  = 1'b0;
        if (in_length == '0) begin
          res_status_nxt = STAT_OK;
        end else if (len_over_chunk) begin
          res_status_nxt = STAT_RANGE;
        end else if (len_c > fill_c) begin
          res_status_nxt = STAT_SHORT;
        end else if (in_command == CMD_READ) begin
          rd_idx_nxt = idx_add(rd_idx_r, SUM_W'(in_length));
          full_nxt   = 1'b0;
        end
      end
      CMD_DISCARD: begin
        blk_left_nxt = '0;
        blk_rej_nxt  = 1'b0;
        if (len_c > fill_c) begin
          rd_idx_nxt    = '0;
          wr_idx_nxt    = '0;
          full_nxt      = 1'b0;
          res_count_nxt = LEN_W'(fill);
        end else begin
          res_count_nxt = in_length;
          if (in_length != '0) begin
            rd_idx_nxt = idx_add(rd_idx_r, SUM_W'(in_length));
            full_nxt   = 1'b0;
          end
        end
      end
      CMD_CLEAR: begin
        blk_left_nxt = '0;
        blk_rej_nxt  = 1'b0;
        rd_idx_nxt   = '0;
        wr_idx_nxt   = '0;
        full_nxt     = 1'b0;
      end
      default: begin
        // unknown command leaves everything as it is
        res_status_nxt = STAT_OK;
      end
    endcase
  end

  // byte store write port
  always_ff @(posedge clk) begin
    if (cmd.accept && mem_we) begin
      mem[wr_idx_r] <= in_data_byte;
    end
  end

  // byte store read port for runs
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      mem_q_r <= mem[run_ptr_r];
    end
  end

  // buffer state and run counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r     <= '0;
      wr_idx_r     <= '0;
      full_r       <= 1'b0;
      blk_left_r   <= '0;
      blk_rej_r    <= 1'b0;
      issue_left_r <= '0;
      load_left_r  <= '0;
      pend_r       <= 1'b0;
    end else begin
      if (cmd.accept) begin
        rd_idx_r   <= rd_idx_nxt;
        wr_idx_r   <= wr_idx_nxt;
        full_r     <= full_nxt;
        blk_left_r <= blk_left_nxt;
        blk_rej_r  <= blk_rej_nxt;
      end
      if (cmd.accept && run_ok) begin
        issue_left_r <= CHUNK_W'(in_length);
        load_left_r  <= CHUNK_W'(in_length);
      end else begin
        if (cmd.issue) begin
          issue_left_r <= issue_left_r - CHUNK_W'(1);
        end
        if (cmd.load) begin
          load_left_r <= load_left_r - CHUNK_W'(1);
        end
      end
      if (cmd.issue) begin
        pend_r <= 1'b1;
      end else if (cmd.load) begin
        pend_r <= 1'b0;
      end
    end
  end

  // run pointer and length
  always_ff @(posedge clk) begin
    if (cmd.accept && run_ok) begin
      run_ptr_r <= rd_idx_r;
      run_len_r <= CHUNK_W'(in_length);
    end else if (cmd.issue) begin
      run_ptr_r <= idx_add(run_ptr_r, SUM_W'(1));
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_byte_r   <= mem_q_r;
      res_status_r <= STAT_OK;
      res_count_r  <= LEN_W'(run_len_r);
      res_last_r   <= (load_left_r == CHUNK_W'(1));
    end else if (cmd.accept && !run_ok) begin
      res_byte_r   <= '0;
      res_status_r <= res_status_nxt;
      res_count_r  <= res_count_nxt;
      res_last_r   <= res_last_nxt;
    end
  end

  // status to the controller
  always_comb begin
    stat.run_start = run_ok;
    stat.more      = (issue_left_r != '0);
    stat.pend      = pend_r;
    stat.last_load = (load_left_r == CHUNK_W'(1));
  end

  // result fields; level and space follow the state, which holds while stalled
  assign out_read_byte  = res_byte_r;
  assign out_status     = res_status_r;
  assign out_count      = res_count_r;
  assign out_last       = res_last_r;
  assign out_fill_level = LEN_W'(fill);
  assign out_free_space = LEN_W'(free);

`ifndef SYNTH
  // a full buffer has equal indices
  a_full_idx: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> (rd_idx_r == wr_idx_r))
    else $error("full flag set with unequal indices");

  // bytes still to deliver are those fetched plus those not yet fetched
  a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
    load_left_r == (issue_left_r + CHUNK_W'(pend_r)))
    else $error("run counters out of step");

  // a rejected block always has items left to swallow
  a_rej_left: assert property (@(posedge clk) disable iff (!rst_n)
    blk_rej_r |-> (blk_left_r != '0))
    else $error("rejected block with nothing left");
`endif

endmodule

@@ tb/byte_ring_buffer_block_ops_test.sv @@
// byte_ring_buffer_block_ops_test: self-checking testbench for the byte ring buffer.
// A scoreboard class predicts every result; tasks drive write blocks, reads, peeks,
// discards and clears. Depends on brb_pkg and byte_ring_buffer_block_ops.
module byte_ring_buffer_block_ops_test
  import brb_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned RING_SIZE   = DEPTH_DEF;
  localparam int unsigned ITEM_GOAL   = 500;
  localparam int unsigned IDLE_PCT    = 18;
  localparam int unsigned DRAIN_WAIT  = 20;
  localparam int unsigned SHOW_MAX    = 40;

  // command codes the block ignores
  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

  // predicts ring buffer results and checks them in order
  class ring_scoreboard;
    typedef struct packed {
      logic [BYTE_W-1:0] rbyte;
      logic [STAT_W-1:0] status;
      logic [LEN_W-1:0]  count;
      logic [LEN_W-1:0]  fill;
      logic [LEN_W-1:0]  space;
      logic              last;
    } ring_result_t;

    logic [BYTE_W-1:0] ring_mem [RING_SIZE];
    int unsigned       rd_ptr;
    int unsigned       wr_ptr;
    bit                full;
    int unsigned       blk_left;
    bit                blk_bad;
    ring_result_t      pending_results [$];
    int unsigned       errors;

    function new();
      rd_ptr   = 0;
      wr_ptr   = 0;
      full     = 0;
      blk_left = 0;
      blk_bad  = 0;
      errors   = 0;
    endfunction

    function int unsigned held();
      if (full) return RING_SIZE;
      if (wr_ptr >= rd_ptr) return wr_ptr - rd_ptr;
      return RING_SIZE - rd_ptr + wr_ptr;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // queue one result; fill and space reflect the state after the whole step
    function void push_result(logic [BYTE_W-1:0] b, logic [STAT_W-1:0] st,
                              int unsigned cnt, bit lst);
      ring_result_t r;
      r.rbyte  = b;
      r.status = st;
      r.count  = LEN_W'(cnt);
      r.fill   = LEN_W'(held());
      r.space  = LEN_W'(RING_SIZE - held());
      r.last   = lst;
      pending_results.push_back(r);
    endfunction

    // one byte item of a write block
    function void write_step(logic [BYTE_W-1:0] data, int unsigned len, bit start);
      logic [STAT_W-1:0] st;
      int unsigned       cnt;
      st  = STAT_OK;
      cnt = 0;
      if (start) begin
        blk_left = 0;
        blk_bad  = 0;
        if (len == 0) begin
          push_result('0, STAT_OK, 0, 1'b1);
          return;
        end
        if (len > RING_SIZE) st = STAT_RANGE;
        else if (len > RING_SIZE - held()) st = STAT_SHORT;
        blk_bad  = (st != STAT_OK);
        blk_left = len;
      end else if (blk_left == 0) begin
        // stray byte with no block to belong to
        push_result('0, STAT_SHORT, 0, 1'b1);
        return;
      end else if (blk_bad) begin
        st = STAT_SHORT;
      end
      if (!blk_bad) begin
        ring_mem[wr_ptr] = data;
        wr_ptr = (wr_ptr + 1) % RING_SIZE;
        if (wr_ptr == rd_ptr) full = 1;
        cnt = 1;
      end
      blk_left = (blk_left - 1) & 'h1ff;
      if (blk_left == 0) blk_bad = 0;
      push_result('0, st, cnt, blk_left == 0);
    endfunction

    // read or peek run
    function void run_step(int unsigned len, bit consume);
      logic [BYTE_W-1:0] run [$];
      int unsigned       pos;
      pos = rd_ptr;
      if (len == 0) begin
        push_result('0, STAT_OK, 0, 1'b1);
        return;
      end
      if (len > MAX_CHUNK || len > RING_SIZE) begin
        push_result('0, STAT_RANGE, 0, 1'b1);
        return;
      end
      if (len > held()) begin
        push_result('0, STAT_SHORT, 0, 1'b1);
        return;
      end
      for (int unsigned i = 0; i < len; i++) begin
        run.push_back(ring_mem[pos]);
        pos = (pos + 1) % RING_SIZE;
      end
      if (consume) begin
        rd_ptr = pos;
        full   = 0;
      end
      for (int unsigned i = 0; i < len; i++)
        push_result(run[i], STAT_OK, len, i + 1 == len);
    endfunction

    // discard drops bytes, or empties the buffer when asked for too many
    function void discard_step(int unsigned len);
      int unsigned f;
      int unsigned cnt;
      f   = held();
      cnt = len;
      if (len > f) begin
        rd_ptr = 0;
        wr_ptr = 0;
        full   = 0;
        cnt    = f;
      end else if (len > 0) begin
        rd_ptr = (rd_ptr + len) % RING_SIZE;
        full   = 0;
      end
      push_result('0, STAT_OK, cnt, 1'b1);
    endfunction

    // accepted input transaction
    function void take_command(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data,
                               logic [LEN_W-1:0] len, logic start);
      if (cmd == CMD_WRITE) begin
        write_step(data, len, start);
        return;
      end
      if (cmd > CMD_CLEAR) begin
        // unknown command leaves everything alone, even a pending block
        push_result('0, STAT_OK, 0, 1'b1);
        return;
      end
      blk_left = 0;
      blk_bad  = 0;
      case (cmd)
        CMD_READ:    run_step(len, 1'b1);
        CMD_PEEK:    run_step(len, 1'b0);
        CMD_DISCARD: discard_step(len);
        default: begin
          rd_ptr = 0;
          wr_ptr = 0;
          full   = 0;
          push_result('0, STAT_OK, 0, 1'b1);
        end
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= SHOW_MAX) $display("mismatch: %s", msg);
    endtask

    // accepted result transaction against the oldest prediction
    task check_result(ring_result_t got);
      ring_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result byte=%0d status=%0d count=%0d",
                         got.rbyte, got.status, got.count));
        return;
      end
      want = pending_results.pop_front();
      if (got.rbyte !== want.rbyte)
        report($sformatf("read_byte got %0d want %0d", got.rbyte, want.rbyte));
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.count !== want.count)
        report($sformatf("count got %0d want %0d", got.count, want.count));
      if (got.fill !== want.fill)
        report($sformatf("fill_level got %0d want %0d", got.fill, want.fill));
      if (got.space !== want.space)
        report($sformatf("free_space got %0d want %0d", got.space, want.space));
      if (got.last !== want.last)
        report($sformatf("last got %0d want %0d", got.last, want.last));
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [CMD_W-1:0]  in_command;
  logic [BYTE_W-1:0] in_data_byte;
  logic [LEN_W-1:0]  in_length;
  logic              in_block_start;
  logic              out_valid;
  logic              out_stall;
  logic [BYTE_W-1:0] out_read_byte;
  logic [STAT_W-1:0] out_status;
  logic [LEN_W-1:0]  out_count;
  logic [LEN_W-1:0]  out_fill_level;
  logic [LEN_W-1:0]  out_free_space;
  logic              out_last;

  ring_scoreboard sb = new();
  int unsigned    cycles = 0;
  int unsigned    items_sent = 0;
  bit             calm = 1'b0;

  byte_ring_buffer_block_ops u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_data_byte   (in_data_byte),
    .in_length      (in_length),
    .in_block_start (in_block_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_byte  (out_read_byte),
    .out_status     (out_status),
    .out_count      (out_count),
    .out_fill_level (out_fill_level),
    .out_free_space (out_free_space),
    .out_last       (out_last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle counter and run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("[byte_ring_buffer_block_ops] ERROR");
    $finish;
  end

  // result side backpressure, off during the calm stretch
  always @(negedge clk) begin
    out_stall = rst_n && !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_read_byte, out_status, out_count, out_fill_level,
                       out_free_space, out_last});
  end

  // one input transaction, with random idle cycles ahead of it
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data,
                           logic [LEN_W-1:0] len, logic start);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_command     = cmd;
    in_data_byte   = data;
    in_length      = len;
    in_block_start = start;
    do @(posedge clk); while (in_stall);
    sb.take_command(cmd, data, len, start);
    items_sent++;
    @(negedge clk);
  endtask

  // write block of n bytes, of which only the first upto items are sent
  task automatic send_block(int unsigned n, int unsigned upto);
    for (int unsigned i = 0; i < upto; i++)
      send_item(CMD_WRITE, BYTE_W'($urandom_range(255)),
                (i == 0) ? LEN_W'(n) : LEN_W'($urandom_range(511)), i == 0);
  endtask

  // read or peek sized against the current fill level
  task automatic send_run(logic [CMD_W-1:0] cmd);
    int unsigned f;
    int unsigned top;
    f   = sb.held();
    top = ($urandom_range(3) == 0) ? MAX_CHUNK : 16;
    if (top > f) top = f;
    send_item(cmd, BYTE_W'($urandom_range(255)),
              (f == 0) ? LEN_W'($urandom_range(3)) : LEN_W'($urandom_range(1, top)),
              1'($urandom_range(1)));
  endtask

  initial begin
    int unsigned pick;
    int unsigned room;
    int unsigned n;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_command     = CMD_WRITE;
    in_data_byte   = '0;
    in_length      = '0;
    in_block_start = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: edge cases of every command
    send_item(CMD_READ, 8'h00, 9'd1, 1'b0);         // read from empty
    send_item(CMD_WRITE, 8'h11, 9'd0, 1'b1);        // empty write block
    send_item(CMD_WRITE, 8'h22, 9'd5, 1'b0);        // stray write byte
    send_item(CMD_WRITE, 8'h00, 9'd3, 1'b1);
    send_item(CMD_WRITE, 8'hff, 9'd511, 1'b0);
    send_item(CMD_WRITE, 8'ha5, 9'd0, 1'b0);
    send_item(CMD_PEEK, 8'hff, 9'd3, 1'b1);
    send_item(CMD_READ, 8'h00, 9'd0, 1'b0);         // zero length read
    send_item(CMD_PEEK, 8'h00, 9'd0, 1'b0);
    send_item(CMD_READ, 8'h00, 9'd65, 1'b0);        // longer than a chunk
    send_item(CMD_PEEK, 8'h00, 9'd256, 1'b0);
    send_item(CMD_READ, 8'h00, 9'd2, 1'b0);
    send_item(CMD_DISCARD, 8'h00, 9'd0, 1'b0);
    send_item(CMD_DISCARD, 8'h00, 9'd5, 1'b0);      // more than held empties
    send_item(CMD_WRITE, 8'h5a, 9'd257, 1'b1);      // block longer than the store
    send_item(CMD_WRITE, 8'h5b, 9'd0, 1'b0);
    send_item(CMD_UNUSED_FIRST, 8'hff, 9'd511, 1'b1);
    send_item(CMD_UNUSED_LAST, 8'h00, 9'd0, 1'b0);
    send_item(CMD_WRITE, 8'h5c, 9'd0, 1'b0);        // still swallowed
    send_item(CMD_CLEAR, 8'h00, 9'd0, 1'b0);
    send_block(4, 2);                               // interrupted block
    send_item(CMD_PEEK, 8'h00, 9'd2, 1'b0);
    send_item(CMD_WRITE, 8'h77, 9'd0, 1'b0);        // block was cancelled
    send_item(CMD_DISCARD, 8'h00, 9'd256, 1'b1);
    send_item(CMD_PEEK, 8'h00, 9'd1, 1'b0);

    // random: mostly well formed blocks and reads, some broken sequences
    while (items_sent < ITEM_GOAL) begin
      calm = (items_sent >= 250 && items_sent < 330);
      pick = $urandom_range(99);
      room = RING_SIZE - sb.held();
      n    = $urandom_range(1, 24);
      if (pick < 40) begin
        send_block(n, n);
      end else if (pick < 46) begin
        // fill to the brim when close
        if (room > 0 && room <= 80) send_block(room, room);
        else send_block(n, n);
      end else if (pick < 50) begin
        // block that cannot fit, partly sent
        n = (room < RING_SIZE) ? $urandom_range(room + 1, RING_SIZE) : RING_SIZE + 1;
        send_block(n, $urandom_range(1, 4));
      end else if (pick < 54) begin
        n = $urandom_range(2, 20);
        send_block(n, $urandom_range(1, n - 1));
      end else if (pick < 72) begin
        send_run(CMD_READ);
      end else if (pick < 82) begin
        send_run(CMD_PEEK);
      end else if (pick < 86) begin
        send_item($urandom_range(1) ? CMD_READ : CMD_PEEK, BYTE_W'($urandom_range(255)),
                  LEN_W'($urandom_range(RING_SIZE)), 1'($urandom_range(1)));
      end else if (pick < 92) begin
        n = $urandom_range(sb.held() + 8);
        if (n > RING_SIZE) n = RING_SIZE;
        send_item(CMD_DISCARD, BYTE_W'($urandom_range(255)), LEN_W'(n),
                  1'($urandom_range(1)));
      end else if (pick < 94) begin
        send_item(CMD_CLEAR, BYTE_W'($urandom_range(255)), LEN_W'($urandom_range(511)),
                  1'($urandom_range(1)));
      end else if (pick < 96) begin
        send_item(CMD_WRITE, BYTE_W'($urandom_range(255)), LEN_W'($urandom_range(511)),
                  1'b0);
      end else if (pick < 98) begin
        send_item(CMD_WRITE, BYTE_W'($urandom_range(255)), 9'd0, 1'b1);
      end else begin
        send_item(CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)),
                  BYTE_W'($urandom_range(255)), LEN_W'($urandom_range(511)),
                  1'($urandom_range(1)));
      end
    end
    calm     = 1'b0;
    in_valid = 1'b0;

    // drain, then watch for stray results
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("[byte_ring_buffer_block_ops] OK");
    else
      $display("[byte_ring_buffer_block_ops] ERROR");
    $finish;
  end

endmodule

@@ byte_ring_buffer_block_ops.f @@
design/brb_pkg.sv
design/brb_ctrl.sv
design/brb_dp.sv
design/byte_ring_buffer_block_ops.sv
tb/byte_ring_buffer_block_ops_test.sv
